// ===== hw/rtl/egf_pkg.sv =====
package egf_pkg;

    localparam int POS_WIDTH_DEF     = 32;
    localparam int COUNTER_WIDTH_DEF = 16;
    localparam int OUT_WIDTH         = 32;
    localparam int ERR_WIDTH         = 32;
    localparam int NUM_WIDTH         = 15;
    localparam int DEN_WIDTH         = 16;
    localparam int ADEN_WIDTH        = DEN_WIDTH + 1;
    localparam int CFG_DATA_WIDTH    = 16;

    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_PULSE  = 2'd1,
        FUNC_START  = 2'd2,
        FUNC_HALT   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        MODE_HALTED = 2'd0,
        MODE_SYNC   = 2'd1,
        MODE_BAD    = 2'd2
    } t_mode;

    typedef enum logic {
        CFG_RATIO_NUM = 1'b0,
        CFG_RATIO_DEN = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_GEAR = 2'd2,
        ST_DONE = 2'd3
    } t_state;

    typedef struct packed {
        logic                        take;
        logic signed [ERR_WIDTH-1:0] err;
    } t_step_res;

    function automatic logic [ADEN_WIDTH-1:0] f_abs_den(input logic [DEN_WIDTH-1:0] den);
        logic [ADEN_WIDTH-1:0] e;
        e = {den[DEN_WIDTH-1], den};
        return den[DEN_WIDTH-1] ? (~e + ADEN_WIDTH'(1)) : e;
    endfunction

    // Error increment when a step is taken: 2 * (|den| - num).
    function automatic logic signed [ERR_WIDTH-1:0] f_take_inc(
        input logic [ADEN_WIDTH-1:0] aden,
        input logic [NUM_WIDTH-1:0]  num
    );
        logic signed [ADEN_WIDTH+1:0] v;
        v = $signed({1'b0, aden}) - $signed({3'b000, num});
        return ERR_WIDTH'(v <<< 1);
    endfunction

    function automatic logic signed [ERR_WIDTH-1:0] f_skip_inc(
        input logic [ADEN_WIDTH-1:0] aden
    );
        return $signed({{(ERR_WIDTH-ADEN_WIDTH-1){1'b0}}, aden, 1'b0});
    endfunction

endpackage

// ===== hw/rtl/egf_bres_step.sv =====
module egf_bres_step
    import egf_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic signed [ERR_WIDTH-1:0] i_err,
    input  logic                        i_dneg,
    input  logic                        i_move_neg,
    input  logic [NUM_WIDTH-1:0]        i_num,
    input  logic [DEN_WIDTH-1:0]        i_den,
    input  logic [POS_WIDTH-1:0]        i_target,
    output t_step_res                   o_res,
    output logic [POS_WIDTH-1:0]        o_target
);

    logic [ADEN_WIDTH-1:0]       aden;
    logic signed [ERR_WIDTH-1:0] inc;
    logic                        err_pos;

    assign aden    = f_abs_den(i_den);
    assign err_pos = !i_err[ERR_WIDTH-1] && (i_err != '0);

    // Forward counts step on a positive error, reverse counts on a negative one.
    always_comb begin
        o_res.take = i_dneg ? i_err[ERR_WIDTH-1] : err_pos;
        inc        = o_res.take ? f_take_inc(aden, i_num) : f_skip_inc(aden);
        o_res.err  = i_dneg ? (i_err - inc) : (i_err + inc);
        if (o_res.take) begin
            o_target = i_move_neg ? (i_target - POS_WIDTH'(1)) : (i_target + POS_WIDTH'(1));
        end else begin
            o_target = i_target;
        end
    end

endmodule

// ===== hw/rtl/encoder_gear_step_follower.sv =====
// An accepted item passes through ST_EXEC and ST_DONE; a geared encoder sample also
// passes through ST_GEAR once per count of its counter delta (up to 2**(COUNTER_WIDTH-1)).
// No new item is taken until the last one has left ST_DONE, which waits while the output
// register is full; geared samples use the single Bresenham step unit once per count.
// Reset (synchronous, active low) clears positions and error term, sets ratio 1/1,
// forward direction, halted status and no pulsing.
module encoder_gear_step_follower
    import egf_pkg::*;
#(
    parameter int POS_WIDTH     = POS_WIDTH_DEF,
    parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_func,
    input  logic [COUNTER_WIDTH-1:0]  i_counter_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [OUT_WIDTH-1:0]      o_encoder_pos,
    output logic [OUT_WIDTH-1:0]      o_target_pos,
    output logic [OUT_WIDTH-1:0]      o_current_pos,
    output logic                      o_dir_forward,
    output logic                      o_step_enable,
    output logic [1:0]                o_status
);

    t_state                      r_state, n_state;
    logic [NUM_WIDTH-1:0]        r_num;
    logic [DEN_WIDTH-1:0]        r_den;
    t_func                       r_func, n_func;
    logic [COUNTER_WIDTH-1:0]    r_cval, n_cval;
    logic [COUNTER_WIDTH-1:0]    r_last, n_last;
    logic [COUNTER_WIDTH-1:0]    r_cnt, n_cnt;
    logic [POS_WIDTH-1:0]        r_enc, n_enc;
    logic [POS_WIDTH-1:0]        r_target, n_target;
    logic [POS_WIDTH-1:0]        r_axis, n_axis;
    logic signed [ERR_WIDTH-1:0] r_err, n_err;
    logic                        r_step_neg, n_step_neg;
    logic                        r_move_neg, n_move_neg;
    logic                        r_dneg, n_dneg;
    t_mode                       r_mode, n_mode;
    logic                        r_pulsing, n_pulsing;
    logic                        r_chk_gear, n_chk_gear;
    logic                        r_chk_pulse, n_chk_pulse;
    logic                        r_out_valid, n_out_valid;
    logic                        out_load;

    logic [OUT_WIDTH-1:0]        r_o_enc, r_o_target, r_o_axis;
    logic                        r_o_dir, r_o_step;
    t_mode                       r_o_mode;

    t_step_res                   step_res;
    logic [POS_WIDTH-1:0]        step_target;
    logic [COUNTER_WIDTH-1:0]    raw;
    logic [COUNTER_WIDTH-1:0]    mag;
    logic [ADEN_WIDTH-1:0]       aden;
    logic                        ratio_bad;

    egf_bres_step #(
        .POS_WIDTH (POS_WIDTH)
    ) u_step (
        .i_err      (r_err),
        .i_dneg     (r_dneg),
        .i_move_neg (r_move_neg),
        .i_num      (r_num),
        .i_den      (r_den),
        .i_target   (r_target),
        .o_res      (step_res),
        .o_target   (step_target)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);

    assign raw       = r_cval - r_last;
    assign mag       = raw[COUNTER_WIDTH-1] ? (~raw + COUNTER_WIDTH'(1)) : raw;
    assign aden      = f_abs_den(r_den);
    assign ratio_bad = (r_num == '0) || (r_den == '0) || (aden > {2'b00, r_num});

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_cval      = r_cval;
        n_last      = r_last;
        n_cnt       = r_cnt;
        n_enc       = r_enc;
        n_target    = r_target;
        n_axis      = r_axis;
        n_err       = r_err;
        n_step_neg  = r_step_neg;
        n_move_neg  = r_move_neg;
        n_dneg      = r_dneg;
        n_mode      = r_mode;
        n_pulsing   = r_pulsing;
        n_chk_gear  = r_chk_gear;
        n_chk_pulse = r_chk_pulse;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_func  = t_func'(i_func);
                    n_cval  = i_counter_value;
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_chk_gear  = 1'b0;
                n_chk_pulse = 1'b0;
                n_state     = ST_DONE;
                case (r_func)
                    FUNC_SAMPLE: begin
                        n_last = r_cval;
                        if (raw != '0) begin
                            n_enc = r_enc + POS_WIDTH'($signed(raw));
                            if (r_mode == MODE_SYNC && r_target == r_axis) begin
                                n_dneg     = raw[COUNTER_WIDTH-1];
                                n_move_neg = raw[COUNTER_WIDTH-1] ^ r_step_neg;
                                n_cnt      = mag;
                                n_chk_gear = 1'b1;
                                n_state    = ST_GEAR;
                            end
                        end
                    end
                    FUNC_PULSE: begin
                        if (r_pulsing) begin
                            n_axis      = r_move_neg ? (r_axis - POS_WIDTH'(1))
                                                     : (r_axis + POS_WIDTH'(1));
                            n_chk_pulse = 1'b1;
                        end
                    end
                    FUNC_START: begin
                        n_pulsing = 1'b0;
                        if (ratio_bad) begin
                            n_mode = MODE_BAD;
                        end else begin
                            n_step_neg = r_den[DEN_WIDTH-1];
                            n_err      = f_take_inc(aden, r_num);
                            n_axis     = r_target;
                            n_mode     = MODE_SYNC;
                        end
                    end
                    default: begin
                        n_mode    = MODE_HALTED;
                        n_pulsing = 1'b0;
                    end
                endcase
            end
            ST_GEAR: begin
                n_err    = step_res.err;
                n_target = step_target;
                n_cnt    = r_cnt - COUNTER_WIDTH'(1);
                if (r_cnt == COUNTER_WIDTH'(1)) begin
                    n_state = ST_DONE;
                end
            end
            default: begin
                // The result waits here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                    if (r_chk_gear && r_target != r_axis) begin
                        n_pulsing = 1'b1;
                    end
                    if (r_chk_pulse && r_target == r_axis) begin
                        n_pulsing = 1'b0;
                    end
                end
            end
        endcase
        n_out_valid = out_load || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num       <= NUM_WIDTH'(1);
            r_den       <= DEN_WIDTH'(1);
            r_last      <= '0;
            r_enc       <= '0;
            r_target    <= '0;
            r_axis      <= '0;
            r_err       <= '0;
            r_step_neg  <= 1'b0;
            r_move_neg  <= 1'b0;
            r_dneg      <= 1'b0;
            r_mode      <= MODE_HALTED;
            r_pulsing   <= 1'b0;
            r_chk_gear  <= 1'b0;
            r_chk_pulse <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_enc       <= n_enc;
            r_target    <= n_target;
            r_axis      <= n_axis;
            r_err       <= n_err;
            r_step_neg  <= n_step_neg;
            r_move_neg  <= n_move_neg;
            r_dneg      <= n_dneg;
            r_mode      <= n_mode;
            r_pulsing   <= n_pulsing;
            r_chk_gear  <= n_chk_gear;
            r_chk_pulse <= n_chk_pulse;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_RATIO_NUM: r_num <= i_cfg_data[NUM_WIDTH-1:0];
                    CFG_RATIO_DEN: r_den <= i_cfg_data[DEN_WIDTH-1:0];
                    default: r_num <= r_num;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_func <= n_func;
        r_cval <= n_cval;
        r_cnt  <= n_cnt;
        if (out_load) begin
            r_o_enc    <= OUT_WIDTH'(r_enc);
            r_o_target <= OUT_WIDTH'(r_target);
            r_o_axis   <= OUT_WIDTH'(r_axis);
            r_o_dir    <= !r_move_neg;
            r_o_step   <= n_pulsing;
            r_o_mode   <= r_mode;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_encoder_pos = r_o_enc;
    assign o_target_pos  = r_o_target;
    assign o_current_pos = r_o_axis;
    assign o_dir_forward = r_o_dir;
    assign o_step_enable = r_o_step;
    assign o_status      = r_o_mode;

endmodule

// ===== verif/tb_encoder_gear_step_follower.sv =====
module tb_encoder_gear_step_follower;
    import egf_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_func;
    logic [15:0] i_counter_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_encoder_pos;
    logic [31:0] o_target_pos;
    logic [31:0] o_current_pos;
    logic        o_dir_forward;
    logic        o_step_enable;
    logic [1:0]  o_status;

    typedef struct {
        logic [31:0] enc_pos;
        logic [31:0] target_pos;
        logic [31:0] current_pos;
        logic        dir_forward;
        logic        step_enable;
        logic [1:0]  status;
    } follower_view_t;

    // Tracks the follower state item by item and holds the views it should report.
    class gearing_scoreboard;
        logic [14:0]        num;
        logic signed [15:0] den;
        logic [15:0]        last_count;
        logic [31:0]        enc_pos;
        logic [31:0]        target;
        logic [31:0]        axis;
        logic [31:0]        err;
        int                 step_sign;
        int                 move_dir;
        t_mode              mode;
        bit                 pulsing;
        follower_view_t     predicted_views[$];
        int                 errors;
        int                 checked;
        int                 geared;
        int                 steps_taken;
        int                 bad_starts;
        int                 func_count[4];

        function new();
            num        = 15'd1;
            den        = 16'sd1;
            last_count = '0;
            enc_pos    = '0;
            target     = '0;
            axis       = '0;
            err        = '0;
            step_sign  = 1;
            move_dir   = 1;
            mode       = MODE_HALTED;
            pulsing    = 1'b0;
        endfunction

        function void write_reg(t_cfg_index idx, logic [15:0] data);
            if (idx == CFG_RATIO_NUM) begin
                num = data[14:0];
            end else begin
                den = data;
            end
        endfunction

        function int abs_den();
            return (den < 0) ? -int'(den) : int'(den);
        endfunction

        function void gear_sample(logic [15:0] cv);
            logic [15:0] raw;
            int          mag;
            int          dsign;
            int          aden;
            longint      d;
            longint      take_inc;
            raw = cv - last_count;
            last_count = cv;
            if (raw == 16'd0) return;
            if (raw[15]) begin
                dsign = -1;
                mag = 65536 - int'(raw);
                enc_pos = enc_pos - 32'(mag);
            end else begin
                dsign = 1;
                mag = int'(raw);
                enc_pos = enc_pos + 32'(mag);
            end
            // Counts that arrive while the axis is still catching up are not geared.
            if (mode != MODE_SYNC || target != axis) return;
            geared++;
            move_dir = dsign * step_sign;
            aden = abs_den();
            take_inc = longint'(2 * (aden - int'(num)));
            for (int i = 0; i < mag; i++) begin
                d = longint'($signed(err));
                if (dsign > 0) begin
                    if (d > 0) begin
                        target = target + 32'(step_sign);
                        d = d + take_inc;
                    end else begin
                        d = d + longint'(2 * aden);
                    end
                end else begin
                    if (d < 0) begin
                        target = target - 32'(step_sign);
                        d = d - take_inc;
                    end else begin
                        d = d - longint'(2 * aden);
                    end
                end
                err = 32'(d);
            end
            if (target != axis) pulsing = 1'b1;
        endfunction

        function void start_sync();
            int aden;
            aden = abs_den();
            pulsing = 1'b0;
            if (num == 15'd0 || den == 16'sd0 || aden > int'(num)) begin
                mode = MODE_BAD;
                bad_starts++;
                return;
            end
            step_sign = (den < 0) ? -1 : 1;
            err = 32'(2 * (aden - int'(num)));
            axis = target;
            mode = MODE_SYNC;
        endfunction

        function void note_item(t_func f, logic [15:0] cv);
            follower_view_t v;
            func_count[f]++;
            case (f)
                FUNC_SAMPLE: gear_sample(cv);
                FUNC_PULSE: begin
                    if (pulsing) begin
                        steps_taken++;
                        axis = axis + 32'(move_dir);
                        if (axis == target) pulsing = 1'b0;
                    end
                end
                FUNC_START: start_sync();
                default: begin
                    mode = MODE_HALTED;
                    pulsing = 1'b0;
                end
            endcase
            v.enc_pos     = enc_pos;
            v.target_pos  = target;
            v.current_pos = axis;
            v.dir_forward = (move_dir > 0);
            v.step_enable = pulsing;
            v.status      = mode;
            predicted_views.push_back(v);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (errors <= 100) begin
                    $error("%s mismatch: expected 0x%08h, got 0x%08h", field, want, got);
                end
            end
        endfunction

        function void check_result(follower_view_t got);
            follower_view_t want;
            if (predicted_views.size() == 0) begin
                errors++;
                $error("result arrived with no item outstanding");
                return;
            end
            want = predicted_views.pop_front();
            checked++;
            compare_field("encoder_pos", want.enc_pos, got.enc_pos);
            compare_field("target_pos", want.target_pos, got.target_pos);
            compare_field("current_pos", want.current_pos, got.current_pos);
            compare_field("dir_forward", 32'(want.dir_forward), 32'(got.dir_forward));
            compare_field("step_enable", 32'(want.step_enable), 32'(got.step_enable));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction

        function int pending();
            return predicted_views.size();
        endfunction
    endclass

    gearing_scoreboard sb;
    bit                in_idle_on;
    bit                out_idle_on;
    int                big_left;
    int                cfg_writes;

    encoder_gear_step_follower uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_func          (i_func),
        .i_counter_value (i_counter_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_encoder_pos   (o_encoder_pos),
        .o_target_pos    (o_target_pos),
        .o_current_pos   (o_current_pos),
        .o_dir_forward   (o_dir_forward),
        .o_step_enable   (o_step_enable),
        .o_status        (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Timeout: results still outstanding");
        $display("== FAIL ==");
        $finish;
    end

    function automatic int draw_wait(bit on);
        return on ? int'($urandom_range(0, 8)) : 0;
    endfunction

    // Geared samples take one Bresenham step per count, so large deltas are rationed.
    function automatic logic [15:0] next_count(bit geared);
        int r;
        int delta;
        r = $urandom_range(0, 99);
        if (!geared && r < 50) return 16'($urandom);
        if (r < 75) begin
            delta = int'($urandom_range(0, 24)) - 12;
        end else if (r < 97 || (geared && big_left == 0)) begin
            delta = int'($urandom_range(0, 400)) - 200;
        end else begin
            if (geared) big_left--;
            delta = int'($urandom_range(0, 65535));
        end
        return sb.last_count + 16'(delta);
    endfunction

    // Called at a clock edge; returns at the edge where the item is taken.
    task automatic send_item(input t_func f, input logic [15:0] cv);
        int gap;
        gap = draw_wait(in_idle_on);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_func          <= f;
        i_counter_value <= cv;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        sb.note_item(f, cv);
    endtask

    // Leaves valid high so back-to-back writes need no drop; the caller lowers it.
    task automatic write_ratio_reg(input t_cfg_index idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_ratio(input logic [15:0] nd, input logic [15:0] dd);
        if ($urandom_range(0, 1) == 0) begin
            write_ratio_reg(CFG_RATIO_NUM, nd);
            write_ratio_reg(CFG_RATIO_DEN, dd);
        end else begin
            write_ratio_reg(CFG_RATIO_DEN, dd);
            write_ratio_reg(CFG_RATIO_NUM, nd);
        end
    endtask

    task automatic retune_ratio();
        int          kind;
        int          n;
        int          m;
        logic [15:0] nd;
        logic [15:0] dd;
        kind = $urandom_range(0, 99);
        if (kind < 55) begin
            m = $urandom_range(0, 9);
            if (m < 5) n = $urandom_range(1, 16);
            else if (m < 9) n = $urandom_range(17, 1000);
            else n = $urandom_range(1001, 32767);
            m = $urandom_range(1, n);
            dd = ($urandom_range(0, 1) == 1) ? 16'(-m) : 16'(m);
            nd = {1'($urandom_range(0, 1)), 15'(n)};
            write_ratio(nd, dd);
        end else if (kind < 70) begin
            case ($urandom_range(0, 3))
                0: dd = 16'h7FFF;
                1: dd = 16'h8001;
                2: dd = 16'h0001;
                default: dd = 16'hFFFF;
            endcase
            write_ratio({1'($urandom_range(0, 1)), 15'h7FFF}, dd);
        end else if (kind < 80) begin
            // Ratios that a start must reject.
            case ($urandom_range(0, 2))
                0: write_ratio({1'($urandom_range(0, 1)), 15'd0}, 16'($urandom_range(1, 65535)));
                1: write_ratio(16'($urandom_range(1, 32767)), 16'h0000);
                default: begin
                    n = $urandom_range(1, 32766);
                    m = $urandom_range(n + 1, 32768);
                    dd = ($urandom_range(0, 1) == 1) ? 16'(-m) : 16'(m);
                    write_ratio(16'(n), dd);
                end
            endcase
        end else if (kind < 95) begin
            // A single register changes under a running follower.
            if ($urandom_range(0, 1) == 1) begin
                write_ratio_reg(CFG_RATIO_NUM, 16'($urandom_range(0, 65535)));
            end else begin
                write_ratio_reg(CFG_RATIO_DEN, 16'(int'($urandom_range(0, 64)) - 32));
            end
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int              stall;
        follower_view_t  got;
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = draw_wait(out_idle_on);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (o_out_valid !== 1'b1) @(posedge i_clk);
            got.enc_pos     = o_encoder_pos;
            got.target_pos  = o_target_pos;
            got.current_pos = o_current_pos;
            got.dir_forward = o_dir_forward;
            got.step_enable = o_step_enable;
            got.status      = o_status;
            sb.check_result(got);
        end
    end

    initial begin
        int          r;
        int          lag;
        int          counted;
        int          phase_items;
        bit          geared;
        t_func       f;
        logic [15:0] cv;
        sb = new();
        big_left    = 6;
        cfg_writes  = 0;
        in_idle_on  = 1'b1;
        out_idle_on = 1'b1;
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_func          <= FUNC_SAMPLE;
        i_counter_value <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_index     <= CFG_RATIO_NUM;
        i_cfg_data      <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset ratio of one to one.
        send_item(FUNC_SAMPLE, 16'd5);
        send_item(FUNC_PULSE, 16'd0);
        send_item(FUNC_HALT, 16'd0);
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_SAMPLE, 16'd8);
        send_item(FUNC_SAMPLE, 16'd9);
        send_item(FUNC_PULSE, 16'd0);
        send_item(FUNC_PULSE, 16'd0);
        send_item(FUNC_PULSE, 16'd0);
        send_item(FUNC_SAMPLE, 16'hFFFF);
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_SAMPLE, 16'h0000);
        drain();
        write_ratio_reg(CFG_RATIO_NUM, 16'h8000);
        i_cfg_valid <= 1'b0;
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_SAMPLE, 16'h8000);
        drain();
        write_ratio_reg(CFG_RATIO_NUM, 16'h7FFF);
        write_ratio_reg(CFG_RATIO_DEN, 16'h8000);
        i_cfg_valid <= 1'b0;
        send_item(FUNC_START, 16'd0);
        drain();
        write_ratio_reg(CFG_RATIO_DEN, 16'h0000);
        i_cfg_valid <= 1'b0;
        send_item(FUNC_START, 16'd0);
        drain();
        write_ratio_reg(CFG_RATIO_DEN, 16'h8001);
        i_cfg_valid <= 1'b0;
        send_item(FUNC_START, 16'd0);
        // Full-range deltas in both directions, each preceded by a resync.
        send_item(FUNC_SAMPLE, 16'h0000);
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_SAMPLE, 16'h7FFF);
        send_item(FUNC_HALT, 16'd0);
        drain();
        write_ratio_reg(CFG_RATIO_DEN, 16'h7FFF);
        write_ratio_reg(CFG_RATIO_NUM, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_item(FUNC_START, 16'd0);
        send_item(FUNC_SAMPLE, 16'h8003);
        send_item(FUNC_PULSE, 16'd0);

        counted = 0;
        while (counted < 1125) begin
            drain();
            retune_ratio();
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            phase_items = 0;
            while (phase_items < 128 && counted < 1125) begin
                r = $urandom_range(0, 99);
                if (sb.mode != MODE_SYNC) begin
                    if (r < 70) f = FUNC_START;
                    else if (r < 78) f = FUNC_HALT;
                    else if (r < 94) f = FUNC_SAMPLE;
                    else f = FUNC_PULSE;
                end else if (sb.pulsing) begin
                    lag = $signed(sb.target - sb.axis);
                    if (lag < 0) lag = -lag;
                    // A long catch-up is cut short by a resync.
                    if (lag > 48 && r < 50) f = FUNC_START;
                    else if (r < 80) f = FUNC_PULSE;
                    else if (r < 93) f = FUNC_SAMPLE;
                    else if (r < 97) f = FUNC_HALT;
                    else f = FUNC_START;
                end else begin
                    if (r < 82) f = FUNC_SAMPLE;
                    else if (r < 90) f = FUNC_PULSE;
                    else if (r < 95) f = FUNC_START;
                    else f = FUNC_HALT;
                end
                geared = (sb.mode == MODE_SYNC) && (sb.target == sb.axis);
                cv = (f == FUNC_SAMPLE) ? next_count(geared) : 16'($urandom);
                if (!(f == FUNC_PULSE && !sb.pulsing)) begin
                    phase_items++;
                    counted++;
                end
                send_item(f, cv);
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d samples (%0d geared), %0d pulse-done, %0d starts, %0d halts; %0d ratio writes.",
                 sb.func_count[FUNC_SAMPLE], sb.geared, sb.func_count[FUNC_PULSE],
                 sb.func_count[FUNC_START], sb.func_count[FUNC_HALT], cfg_writes);
        $display("Checked %0d results: %0d steps applied, %0d rejected ratios, %0d mismatches.",
                 sb.checked, sb.steps_taken, sb.bad_starts, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
